// ===== hdl/drs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package drs_pkg;

    typedef struct packed {
        logic        req_valid;
        logic [15:0] tag;
        logic [2:0]  proc;
        logic [2:0]  bank;
        logic [15:0] row;
        logic        ok;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic        mark;
        logic        issued;
        logic [15:0] tag;
        logic [2:0]  proc;
        logic [2:0]  bank;
        logic [15:0] row;
    } qent_t;

    typedef struct packed {
        logic [1:0] policy;
        logic [7:0] hit_lat;
        logic [7:0] miss_lat;
        logic [3:0] cap;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  bank_index;
        logic        issued;
        logic [15:0] issued_tag;
        logic [2:0]  issued_proc;
        logic [15:0] issued_row;
        logic        row_hit;
        logic        req_accepted;
        logic        busy_res;
        logic        last;
    } res_t;

    localparam logic [1:0] REG_POLICY = 2'd0;
    localparam logic [1:0] REG_HIT    = 2'd1;
    localparam logic [1:0] REG_MISS   = 2'd2;
    localparam logic [1:0] REG_CAP    = 2'd3;

    localparam logic [1:0] POL_FCFS   = 2'd0;
    localparam logic [1:0] POL_FRFCFS = 2'd1;
    localparam logic [1:0] POL_PARBS  = 2'd2;
    localparam logic [1:0] POL_NONE   = 2'd3;

endpackage
`default_nettype wire

// ===== hdl/drs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module drs_front #(
    parameter int NUM_BANKS = 8,
    parameter int NUM_PROCS = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_req_valid,
    input  wire logic [15:0]   s_req_tag,
    input  wire logic [2:0]    s_req_proc,
    input  wire logic [2:0]    s_req_bank,
    input  wire logic [15:0]   s_req_row,
    output logic               out_valid,
    input  wire logic          out_ready,
    output drs_pkg::item_t     out_item
);

    drs_pkg::item_t mem_reg [2];
    logic           wp_reg, wp_next;
    logic           rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    drs_pkg::item_t in_item;
    logic           push, pop;

    // range check done here so the back end only sees a flag
    always_comb begin
        in_item.req_valid = s_req_valid;
        in_item.tag       = s_req_tag;
        in_item.proc      = s_req_proc;
        in_item.bank      = s_req_bank;
        in_item.row       = s_req_row;
        in_item.ok        = (32'(s_req_proc) < NUM_PROCS) && (32'(s_req_bank) < NUM_BANKS);
    end

    assign s_ready   = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rp_reg];
    assign push      = s_valid && s_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ pop;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wp_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/drs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module drs_back #(
    parameter int NUM_BANKS   = 8,
    parameter int NUM_PROCS   = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire drs_pkg::cfg_t  cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire drs_pkg::item_t in_item,
    output logic                m_valid,
    input  wire logic           m_ready,
    output drs_pkg::res_t       m_res
);

    localparam int QW   = $clog2(QUEUE_DEPTH);
    localparam int BW   = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int RW   = $clog2(NUM_PROCS + 1);
    localparam int NREP = (NUM_BANKS < 8) ? NUM_BANKS : 8;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FREE   = 3'd1;
    localparam logic [2:0] S_MARK   = 3'd2;
    localparam logic [2:0] S_LOAD   = 3'd3;
    localparam logic [2:0] S_RANK   = 3'd4;
    localparam logic [2:0] S_BANK   = 3'd5;
    localparam logic [2:0] S_ACCEPT = 3'd6;
    localparam logic [2:0] S_EMIT   = 3'd7;

    logic [2:0]     state_reg, state_next;
    drs_pkg::qent_t q_reg [QUEUE_DEPTH];
    drs_pkg::qent_t q_next [QUEUE_DEPTH];
    drs_pkg::item_t item_reg, item_next;
    logic           acc_reg, acc_next;
    logic           qne_reg, qne_next;
    logic           busy_reg, busy_next;
    logic [QW-1:0]  ptr_reg, ptr_next;
    logic [BW-1:0]  bank_reg, bank_next;
    logic [7:0]     timer_reg [NUM_BANKS];
    logic [7:0]     timer_next [NUM_BANKS];
    logic           ropen_reg [NUM_BANKS];
    logic           ropen_next [NUM_BANKS];
    logic [15:0]    orow_reg [NUM_BANKS];
    logic [15:0]    orow_next [NUM_BANKS];
    logic [RW-1:0]  rank_reg [NUM_PROCS];
    logic [RW-1:0]  rank_next [NUM_PROCS];
    logic [CW-1:0]  load_reg [NUM_PROCS];
    logic [CW-1:0]  load_next [NUM_PROCS];
    logic [CW-1:0]  total_reg [NUM_PROCS];
    logic [CW-1:0]  total_next [NUM_PROCS];
    logic           riss_reg [NUM_BANKS];
    logic           riss_next [NUM_BANKS];
    logic           rhit_reg [NUM_BANKS];
    logic           rhit_next [NUM_BANKS];
    logic [15:0]    rtag_reg [NUM_BANKS];
    logic [15:0]    rtag_next [NUM_BANKS];
    logic [2:0]     rproc_reg [NUM_BANKS];
    logic [2:0]     rproc_next [NUM_BANKS];
    logic [15:0]    rrow_reg [NUM_BANKS];
    logic [15:0]    rrow_next [NUM_BANKS];
    drs_pkg::res_t  out_reg, out_next;
    logic           mval_reg, mval_next;

    // queue scans
    logic           fi_found;
    logic [QW-1:0]  fi_idx;
    logic           any_marked;
    logic [QW-1:0]  ins_idx;
    logic [CW-1:0]  mark_cnt;
    logic [CW-1:0]  cnt_pb [NUM_PROCS];
    logic [CW-1:0]  tot_p [NUM_PROCS];
    logic [RW-1:0]  rank_new [NUM_PROCS];
    logic           any_timer;

    // bank pick
    logic [QUEUE_DEPTH-1:0] cand;
    logic [QUEUE_DEPTH-1:0] hitv;
    logic [1:0]     cls [QUEUE_DEPTH];
    logic [RW-1:0]  rk [QUEUE_DEPTH];
    logic [1:0]     bestc;
    logic [RW-1:0]  vmin;
    logic [QW-1:0]  sel;
    logic           pick_found;
    logic [7:0]     tcur, tdec;
    logic           do_iss;

    always_comb begin
        logic [QUEUE_DEPTH-1:0] mv;
        fi_found   = 1'b0;
        fi_idx     = '0;
        any_marked = 1'b0;
        ins_idx    = '0;
        for (int r = QUEUE_DEPTH - 1; r >= 0; r--) begin
            if (q_reg[r].valid && q_reg[r].issued) begin
                fi_found = 1'b1;
                fi_idx   = QW'(r);
            end
            if (!q_reg[r].valid) begin
                ins_idx = QW'(r);
            end
            if (q_reg[r].valid && q_reg[r].mark) begin
                any_marked = 1'b1;
            end
        end
        for (int r = 0; r < QUEUE_DEPTH; r++) begin
            mv[r] = q_reg[r].valid && q_reg[r].mark &&
                    q_reg[r].proc == q_reg[ptr_reg].proc &&
                    q_reg[r].bank == q_reg[ptr_reg].bank;
        end
        mark_cnt = CW'($countones(mv));
    end

    always_comb begin
        logic [QUEUE_DEPTH-1:0] vb;
        logic [QUEUE_DEPTH-1:0] vt;
        for (int p = 0; p < NUM_PROCS; p++) begin
            for (int r = 0; r < QUEUE_DEPTH; r++) begin
                vt[r] = q_reg[r].valid && q_reg[r].mark && 32'(q_reg[r].proc) == p;
                vb[r] = vt[r] && 32'(q_reg[r].bank) == 32'(bank_reg);
            end
            cnt_pb[p] = CW'($countones(vb));
            tot_p[p]  = CW'($countones(vt));
        end
    end

    // lower rank wins: lower max load, then lower total, then higher id
    always_comb begin
        logic [NUM_PROCS-1:0] beats;
        for (int p = 0; p < NUM_PROCS; p++) begin
            for (int q = 0; q < NUM_PROCS; q++) begin
                beats[q] = (q != p) &&
                    (load_reg[q] < load_reg[p] ||
                     (load_reg[q] == load_reg[p] &&
                      (total_reg[q] < total_reg[p] ||
                       (total_reg[q] == total_reg[p] && q > p))));
            end
            rank_new[p] = RW'($countones(beats));
        end
    end

    always_comb begin
        any_timer = 1'b0;
        for (int b = 0; b < NUM_BANKS; b++) begin
            any_timer = any_timer || (timer_reg[b] != 8'd0);
        end
    end

    always_comb begin
        logic [3:0] cex;
        logic       ex;
        logic       vf;
        logic       sf;
        for (int r = 0; r < QUEUE_DEPTH; r++) begin
            cand[r] = q_reg[r].valid && !q_reg[r].issued &&
                      32'(q_reg[r].bank) == 32'(bank_reg) &&
                      cfg.policy != drs_pkg::POL_NONE;
            hitv[r] = ropen_reg[bank_reg] && orow_reg[bank_reg] == q_reg[r].row;
            case (cfg.policy)
                drs_pkg::POL_FRFCFS: cls[r] = {1'b0, !hitv[r]};
                drs_pkg::POL_PARBS:  cls[r] = {!q_reg[r].mark, !hitv[r]};
                default:             cls[r] = 2'd0;
            endcase
            rk[r] = '0;
            if (cfg.policy == drs_pkg::POL_PARBS) begin
                for (int p = 0; p < NUM_PROCS; p++) begin
                    if (32'(q_reg[r].proc) == p) begin
                        rk[r] = rank_reg[p];
                    end
                end
            end
        end
        for (int c = 0; c < 4; c++) begin
            cex[c] = 1'b0;
            for (int r = 0; r < QUEUE_DEPTH; r++) begin
                cex[c] = cex[c] || (cand[r] && 32'(cls[r]) == c);
            end
        end
        bestc = 2'd3;
        for (int c = 3; c >= 0; c--) begin
            if (cex[c]) begin
                bestc = 2'(c);
            end
        end
        vmin = '0;
        vf   = 1'b0;
        for (int v = 0; v <= NUM_PROCS; v++) begin
            ex = 1'b0;
            for (int r = 0; r < QUEUE_DEPTH; r++) begin
                ex = ex || (cand[r] && cls[r] == bestc && 32'(rk[r]) == v);
            end
            if (ex && !vf) begin
                vf   = 1'b1;
                vmin = RW'(v);
            end
        end
        sel = '0;
        sf  = 1'b0;
        for (int r = 0; r < QUEUE_DEPTH; r++) begin
            if (!sf && cand[r] && cls[r] == bestc && rk[r] == vmin) begin
                sf  = 1'b1;
                sel = QW'(r);
            end
        end
        pick_found = |cand;
    end

    assign tcur   = timer_reg[bank_reg];
    assign tdec   = (tcur == 8'd0) ? 8'd0 : tcur - 8'd1;
    assign do_iss = (tdec == 8'd0) && qne_reg && pick_found;

    assign in_ready = (state_reg == S_IDLE);
    assign m_valid  = mval_reg;
    assign m_res    = out_reg;

    always_comb begin
        state_next = state_reg;
        q_next     = q_reg;
        item_next  = item_reg;
        acc_next   = acc_reg;
        qne_next   = qne_reg;
        busy_next  = busy_reg;
        ptr_next   = ptr_reg;
        bank_next  = bank_reg;
        timer_next = timer_reg;
        ropen_next = ropen_reg;
        orow_next  = orow_reg;
        rank_next  = rank_reg;
        load_next  = load_reg;
        total_next = total_reg;
        riss_next  = riss_reg;
        rhit_next  = rhit_reg;
        rtag_next  = rtag_reg;
        rproc_next = rproc_reg;
        rrow_next  = rrow_reg;
        out_next   = out_reg;
        mval_next  = mval_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    item_next  = in_item;
                    state_next = S_FREE;
                end
            end
            S_FREE: begin
                if (fi_found) begin
                    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                        if (32'(i) >= 32'(fi_idx)) begin
                            q_next[i] = q_reg[i + 1];
                        end
                    end
                    q_next[QUEUE_DEPTH - 1] = '0;
                end else begin
                    acc_next = item_reg.req_valid && item_reg.ok &&
                               !q_reg[QUEUE_DEPTH - 1].valid;
                    qne_next = q_reg[0].valid;
                    ptr_next = '0;
                    bank_next = '0;
                    state_next = any_marked ? S_BANK : S_MARK;
                end
            end
            S_MARK: begin
                if (q_reg[ptr_reg].valid && 32'(mark_cnt) < 32'(cfg.cap)) begin
                    q_next[ptr_reg].mark = 1'b1;
                end
                if (32'(ptr_reg) == QUEUE_DEPTH - 1) begin
                    for (int p = 0; p < NUM_PROCS; p++) begin
                        load_next[p] = '0;
                    end
                    bank_next  = '0;
                    state_next = S_LOAD;
                end else begin
                    ptr_next = ptr_reg + QW'(1);
                end
            end
            S_LOAD: begin
                for (int p = 0; p < NUM_PROCS; p++) begin
                    if (cnt_pb[p] > load_reg[p]) begin
                        load_next[p] = cnt_pb[p];
                    end
                    total_next[p] = tot_p[p];
                end
                if (32'(bank_reg) == NUM_BANKS - 1) begin
                    state_next = S_RANK;
                end else begin
                    bank_next = bank_reg + BW'(1);
                end
            end
            S_RANK: begin
                rank_next  = rank_new;
                bank_next  = '0;
                state_next = S_BANK;
            end
            S_BANK: begin
                timer_next[bank_reg] = tdec;
                riss_next[bank_reg]  = do_iss;
                rhit_next[bank_reg]  = 1'b0;
                rtag_next[bank_reg]  = '0;
                rproc_next[bank_reg] = '0;
                rrow_next[bank_reg]  = '0;
                if (do_iss) begin
                    q_next[sel].issued   = 1'b1;
                    timer_next[bank_reg] = hitv[sel] ? cfg.hit_lat : cfg.miss_lat;
                    ropen_next[bank_reg] = 1'b1;
                    orow_next[bank_reg]  = q_reg[sel].row;
                    rhit_next[bank_reg]  = hitv[sel];
                    rtag_next[bank_reg]  = q_reg[sel].tag;
                    rproc_next[bank_reg] = q_reg[sel].proc;
                    rrow_next[bank_reg]  = q_reg[sel].row;
                end
                if (32'(bank_reg) == NUM_BANKS - 1) begin
                    state_next = S_ACCEPT;
                end else begin
                    bank_next = bank_reg + BW'(1);
                end
            end
            S_ACCEPT: begin
                if (acc_reg) begin
                    q_next[ins_idx].valid  = 1'b1;
                    q_next[ins_idx].mark   = 1'b0;
                    q_next[ins_idx].issued = 1'b0;
                    q_next[ins_idx].tag    = item_reg.tag;
                    q_next[ins_idx].proc   = item_reg.proc;
                    q_next[ins_idx].bank   = item_reg.bank;
                    q_next[ins_idx].row    = item_reg.row;
                end
                busy_next  = q_reg[0].valid || acc_reg || any_timer;
                bank_next  = '0;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (!mval_reg || m_ready) begin
                    out_next.bank_index   = 3'(bank_reg);
                    out_next.issued       = riss_reg[bank_reg];
                    out_next.issued_tag   = rtag_reg[bank_reg];
                    out_next.issued_proc  = rproc_reg[bank_reg];
                    out_next.issued_row   = rrow_reg[bank_reg];
                    out_next.row_hit      = rhit_reg[bank_reg];
                    out_next.req_accepted = acc_reg;
                    out_next.busy_res     = busy_reg;
                    out_next.last         = (32'(bank_reg) == NREP - 1);
                    mval_next             = 1'b1;
                    if (32'(bank_reg) == NREP - 1) begin
                        state_next = S_IDLE;
                    end else begin
                        bank_next = bank_reg + BW'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mval_reg  <= 1'b0;
            for (int r = 0; r < QUEUE_DEPTH; r++) begin
                q_reg[r] <= '0;
            end
            for (int b = 0; b < NUM_BANKS; b++) begin
                timer_reg[b] <= '0;
                ropen_reg[b] <= 1'b0;
            end
            for (int p = 0; p < NUM_PROCS; p++) begin
                rank_reg[p] <= RW'(NUM_PROCS);
            end
        end else begin
            state_reg  <= state_next;
            mval_reg   <= mval_next;
            q_reg      <= q_next;
            timer_reg  <= timer_next;
            ropen_reg  <= ropen_next;
            rank_reg   <= rank_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        acc_reg   <= acc_next;
        qne_reg   <= qne_next;
        busy_reg  <= busy_next;
        ptr_reg   <= ptr_next;
        bank_reg  <= bank_next;
        orow_reg  <= orow_next;
        load_reg  <= load_next;
        total_reg <= total_next;
        riss_reg  <= riss_next;
        rhit_reg  <= rhit_next;
        rtag_reg  <= rtag_next;
        rproc_reg <= rproc_next;
        rrow_reg  <= rrow_next;
        out_reg   <= out_next;
    end

endmodule
`default_nettype wire

// ===== hdl/dram_request_scheduler.sv =====
// channel | dir | handshake            | payload
// s_      | in  | s_valid / s_ready    | req_valid, req_tag, req_proc, req_bank, req_row
// m_      | out | m_valid / m_ready    | bank report, one per bank up to 8, last on final report
// cfg_    | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item is one controller tick: it is taken, issued entries are freed one at a time,
// a batch is marked and ranked when no entry is marked, each bank in turn may issue one
// entry, the new request is accepted, then the bank reports go out in bank order.
// Reset (synchronous, aresetn low) empties the queue, stops all timers, closes all rows.
// A two-entry input queue takes up to two items while the back end works; a stalled m_ready
// holds the back end in its report phase.
`timescale 1ns / 1ps
`default_nettype none
module dram_request_scheduler #(
    parameter int NUM_BANKS   = 8,
    parameter int NUM_PROCS   = 8,
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_valid,
    input  wire logic [15:0] s_req_tag,
    input  wire logic [2:0]  s_req_proc,
    input  wire logic [2:0]  s_req_bank,
    input  wire logic [15:0] s_req_row,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_bank_index,
    output logic             m_issued,
    output logic [15:0]      m_issued_tag,
    output logic [2:0]       m_issued_proc,
    output logic [15:0]      m_issued_row,
    output logic             m_row_hit,
    output logic             m_req_accepted,
    output logic             m_busy_res,
    output logic             m_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    drs_pkg::cfg_t  cfg_reg, cfg_next;
    drs_pkg::item_t f_item;
    drs_pkg::res_t  res;
    logic           f_valid, f_ready;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                drs_pkg::REG_POLICY: cfg_next.policy   = cfg_data[1:0];
                drs_pkg::REG_HIT:    cfg_next.hit_lat  = cfg_data;
                drs_pkg::REG_MISS:   cfg_next.miss_lat = cfg_data;
                drs_pkg::REG_CAP:    cfg_next.cap      = cfg_data[3:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.policy   <= drs_pkg::POL_FCFS;
            cfg_reg.hit_lat  <= 8'd4;
            cfg_reg.miss_lat <= 8'd12;
            cfg_reg.cap      <= 4'd5;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    drs_front #(
        .NUM_BANKS (NUM_BANKS),
        .NUM_PROCS (NUM_PROCS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req_valid (s_req_valid),
        .s_req_tag   (s_req_tag),
        .s_req_proc  (s_req_proc),
        .s_req_bank  (s_req_bank),
        .s_req_row   (s_req_row),
        .out_valid   (f_valid),
        .out_ready   (f_ready),
        .out_item    (f_item)
    );

    drs_back #(
        .NUM_BANKS   (NUM_BANKS),
        .NUM_PROCS   (NUM_PROCS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_item  (f_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (res)
    );

    assign m_bank_index   = res.bank_index;
    assign m_issued       = res.issued;
    assign m_issued_tag   = res.issued_tag;
    assign m_issued_proc  = res.issued_proc;
    assign m_issued_row   = res.issued_row;
    assign m_row_hit      = res.row_hit;
    assign m_req_accepted = res.req_accepted;
    assign m_busy_res     = res.busy_res;
    assign m_last         = res.last;

    a_idle_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_issued |-> m_issued_tag == 16'd0 && !m_row_hit)
        else $error("idle bank report carries data");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_req_accepted |-> m_busy_res)
        else $error("accepted request but not busy");

    a_bank_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=>
            m_valid && m_bank_index == 3'($past(m_bank_index) + 3'd1))
        else $error("bank reports out of order");

endmodule
`default_nettype wire
